// File: hw/rtl/pjb_pkg.sv
`timescale 1ns / 1ps

package pjb_pkg;

  typedef enum logic [2:0] {
    CMD_WRITE    = 3'd0,
    CMD_PULL     = 3'd1,
    CMD_START    = 3'd2,
    CMD_STOP     = 3'd3,
    CMD_FLUSH    = 3'd4,
    CMD_CLEAR_EV = 3'd5
  } cmd_e;

  localparam logic REG_VOLUME = 1'b0;
  localparam logic REG_PERIOD = 1'b1;

  localparam int EV_UNDERRUN_BIT = 0;
  localparam int EV_OVERFLOW_BIT = 1;

  localparam int SAMPLE_W = 16;
  localparam int VOL_W    = 7;
  localparam int PERIOD_W = 8;
  localparam int SIL_W    = 16;

  localparam logic [VOL_W-1:0] VOL_MAX     = 7'd100;
  localparam logic [VOL_W-1:0] VOL_RESET   = 7'd75;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd16;

  // |sample| * volume fits 22 bits; /100 as multiply by ceil(2^29/100) >> 29
  localparam int PROD_W     = 22;
  localparam int DIV_MULT_W = 23;
  localparam int DIV_SHIFT  = 29;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = 23'd5368710;

  localparam int QUEUE_DEPTH = 4;
  localparam int QLVL_W      = 3;
  localparam int QPTR_W      = 2;

  typedef struct packed {
    logic       active;
    logic [1:0] events;
    logic       last;
  } status_t;

endpackage

// File: hw/rtl/pjb_store.sv
`timescale 1ns / 1ps

module pjb_store #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [AW-1:0]                waddr_i,
  input  logic [pjb_pkg::SAMPLE_W-1:0] wdata_i,
  input  logic                         re_i,
  input  logic [AW-1:0]                raddr_i,
  output logic [pjb_pkg::SAMPLE_W-1:0] rdata_o
);

  logic [pjb_pkg::SAMPLE_W-1:0] mem [DEPTH];
  logic [pjb_pkg::SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/pjb_queue.sv
`timescale 1ns / 1ps

module pjb_queue #(
  parameter int W = 35
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [W-1:0]               data_i,
  input  logic                       pop_i,
  output logic                       valid_o,
  output logic [W-1:0]               data_o,
  output logic [pjb_pkg::QLVL_W-1:0] level_o
);

  logic [W-1:0]               entry_q [pjb_pkg::QUEUE_DEPTH];
  logic [pjb_pkg::QPTR_W-1:0] head_q, head_d;
  logic [pjb_pkg::QPTR_W-1:0] tail_q, tail_d;
  logic [pjb_pkg::QLVL_W-1:0] count_q, count_d;
  logic                       do_pop;

  assign valid_o = (count_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign data_o  = entry_q[head_q];
  assign level_o = count_q;

  always_comb begin
    head_d  = do_pop ? head_q + pjb_pkg::QPTR_W'(1) : head_q;
    tail_d  = push_i ? tail_q + pjb_pkg::QPTR_W'(1) : tail_q;
    count_d = count_q;
    if (push_i && !do_pop) begin
      count_d = count_q + pjb_pkg::QLVL_W'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - pjb_pkg::QLVL_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[tail_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/pjb_front.sv
`timescale 1ns / 1ps

module pjb_front #(
  parameter int FIFO_SAMPLES   = 8192,
  parameter int BLOCK_FRAMES   = 256,
  parameter int IDLE_STOP_TIME = 400,
  parameter int PTR_W          = 13,
  parameter int FILL_W         = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   cmd_i,
  input  logic [pjb_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [7:0]                   cfg_wdata_i,
  input  logic [pjb_pkg::QLVL_W-1:0]   q_level_i,
  output logic                         q_push_o,
  output logic [pjb_pkg::SAMPLE_W-1:0] q_sample_o,
  output pjb_pkg::status_t             q_status_o,
  output logic [FILL_W-1:0]            q_fill_o,
  output logic [pjb_pkg::VOL_W-1:0]    volume_o,
  output logic                         st_we_o,
  output logic [PTR_W-1:0]             st_waddr_o,
  output logic [pjb_pkg::SAMPLE_W-1:0] st_wdata_o,
  output logic                         st_re_o,
  output logic [PTR_W-1:0]             st_raddr_o,
  input  logic [pjb_pkg::SAMPLE_W-1:0] st_rdata_i
);

  localparam int FI_W = $clog2(BLOCK_FRAMES);
  localparam int BR_W = $clog2(BLOCK_FRAMES + 1);

  logic [PTR_W-1:0]               rd_q, rd_d, wr_q, wr_d;
  logic [FILL_W-1:0]              held_q, held_d;
  logic                           run_q, run_d;
  logic [1:0]                     ev_q, ev_d, ev_out;
  logic [FI_W-1:0]                fi_q, fi_d;
  logic [BR_W-1:0]                br_q, br_d;
  logic [pjb_pkg::SIL_W-1:0]      sil_q, sil_d;
  logic [pjb_pkg::VOL_W-1:0]      vol_q, vol_d;
  logic [pjb_pkg::PERIOD_W-1:0]   per_q, per_d;

  logic                           desc_v_q;
  logic                           desc_pop_q;
  pjb_pkg::status_t               desc_status_q;
  logic [FILL_W-1:0]              desc_fill_q;

  logic                           accept;
  logic                           pop;
  logic                           last;
  logic [BR_W-1:0]                got;
  logic [BR_W-1:0]                fi_plus;
  logic [pjb_pkg::PERIOD_W-1:0]   bms;
  logic [pjb_pkg::SIL_W:0]        sil_sum;
  logic [pjb_pkg::SIL_W-1:0]      sil_new;
  logic [pjb_pkg::VOL_W-1:0]      vol_wr;

  assign in_stall_o = (32'(q_level_i) + 32'(desc_v_q)) >= 32'(pjb_pkg::QUEUE_DEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    vol_d  = vol_q;
    per_d  = per_q;
    vol_wr = cfg_wdata_i[pjb_pkg::VOL_W-1:0];
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        pjb_pkg::REG_VOLUME: vol_d = (vol_wr > pjb_pkg::VOL_MAX) ? pjb_pkg::VOL_MAX : vol_wr;
        pjb_pkg::REG_PERIOD: per_d = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_d    = rd_q;
    wr_d    = wr_q;
    held_d  = held_q;
    run_d   = run_q;
    ev_d    = ev_q;
    fi_d    = fi_q;
    br_d    = br_q;
    sil_d   = sil_q;
    pop     = 1'b0;
    last    = 1'b0;
    st_we_o = 1'b0;
    got     = br_q;
    fi_plus = BR_W'(fi_q) + BR_W'(1);
    bms     = (per_q == '0) ? pjb_pkg::PERIOD_W'(1) : per_q;
    sil_sum = {1'b0, sil_q} + (pjb_pkg::SIL_W + 1)'(bms);
    sil_new = sil_sum[pjb_pkg::SIL_W] ? '1 : sil_sum[pjb_pkg::SIL_W-1:0];
    if (fi_q == '0) begin
      got = (32'(held_q) < 32'(BLOCK_FRAMES)) ? BR_W'(held_q) : BR_W'(BLOCK_FRAMES);
    end
    if (accept) begin
      unique case (pjb_pkg::cmd_e'(cmd_i))
        pjb_pkg::CMD_WRITE: begin
          if (run_q) begin
            if (32'(held_q) < 32'(FIFO_SAMPLES)) begin
              st_we_o = 1'b1;
              wr_d    = (wr_q == PTR_W'(FIFO_SAMPLES - 1)) ? '0 : wr_q + PTR_W'(1);
              held_d  = held_q + FILL_W'(1);
            end else begin
              ev_d[pjb_pkg::EV_OVERFLOW_BIT] = 1'b1;
            end
          end
        end
        pjb_pkg::CMD_PULL: begin
          if (run_q) begin
            br_d = got;
            if (fi_q == '0 && 32'(got) < 32'(BLOCK_FRAMES)) begin
              ev_d[pjb_pkg::EV_UNDERRUN_BIT] = 1'b1;
            end
            if (32'(fi_q) < 32'(got) && held_q != '0) begin
              pop    = 1'b1;
              rd_d   = (rd_q == PTR_W'(FIFO_SAMPLES - 1)) ? '0 : rd_q + PTR_W'(1);
              held_d = held_q - FILL_W'(1);
            end
            if (fi_plus == BR_W'(BLOCK_FRAMES)) begin
              last  = 1'b1;
              fi_d  = '0;
              sil_d = (got == '0) ? sil_new : '0;
              if (sil_d >= pjb_pkg::SIL_W'(IDLE_STOP_TIME)) begin
                run_d = 1'b0;
              end
            end else begin
              fi_d = FI_W'(fi_plus);
            end
          end
        end
        pjb_pkg::CMD_START: begin
          if (!run_q) begin
            rd_d   = '0;
            wr_d   = '0;
            held_d = '0;
            ev_d   = '0;
            fi_d   = '0;
            br_d   = '0;
            sil_d  = '0;
            run_d  = 1'b1;
          end
        end
        pjb_pkg::CMD_STOP: run_d = 1'b0;
        pjb_pkg::CMD_FLUSH: begin
          rd_d   = '0;
          wr_d   = '0;
          held_d = '0;
          run_d  = 1'b0;
        end
        pjb_pkg::CMD_CLEAR_EV: ev_d = '0;
        default: ;
      endcase
    end
    // read-clear reports the latches as they were
    ev_out = (pjb_pkg::cmd_e'(cmd_i) == pjb_pkg::CMD_CLEAR_EV) ? ev_q : ev_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q     <= '0;
      wr_q     <= '0;
      held_q   <= '0;
      run_q    <= 1'b0;
      ev_q     <= '0;
      fi_q     <= '0;
      br_q     <= '0;
      sil_q    <= '0;
      vol_q    <= pjb_pkg::VOL_RESET;
      per_q    <= pjb_pkg::PERIOD_RESET;
      desc_v_q <= 1'b0;
    end else begin
      rd_q     <= rd_d;
      wr_q     <= wr_d;
      held_q   <= held_d;
      run_q    <= run_d;
      ev_q     <= ev_d;
      fi_q     <= fi_d;
      br_q     <= br_d;
      sil_q    <= sil_d;
      vol_q    <= vol_d;
      per_q    <= per_d;
      desc_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      desc_pop_q           <= pop;
      desc_status_q.active <= run_d;
      desc_status_q.events <= ev_out;
      desc_status_q.last   <= last;
      desc_fill_q          <= held_d;
    end
  end

  assign st_waddr_o = wr_q;
  assign st_wdata_o = sample_i;
  assign st_re_o    = accept && pop;
  assign st_raddr_o = rd_q;

  assign q_push_o   = desc_v_q;
  assign q_sample_o = desc_pop_q ? st_rdata_i : '0;
  assign q_status_o = desc_status_q;
  assign q_fill_o   = desc_fill_q;
  assign volume_o   = vol_q;

endmodule

// File: hw/rtl/pjb_back.sv
`timescale 1ns / 1ps

module pjb_back #(
  parameter int FILL_W = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  output logic                         q_pop_o,
  input  logic [pjb_pkg::SAMPLE_W-1:0] q_sample_i,
  input  pjb_pkg::status_t             q_status_i,
  input  logic [FILL_W-1:0]            q_fill_i,
  input  logic [pjb_pkg::VOL_W-1:0]    volume_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [pjb_pkg::SAMPLE_W-1:0] sample_o,
  output pjb_pkg::status_t             status_o,
  output logic [FILL_W-1:0]            fill_o
);

  localparam int MAG_W  = pjb_pkg::SAMPLE_W + 1;
  localparam int FULL_W = pjb_pkg::PROD_W + pjb_pkg::DIV_MULT_W;

  logic                          a_v_q, b_v_q, c_v_q;
  logic                          a_rdy, b_rdy, c_rdy;
  logic                          a_neg_q, b_neg_q;
  logic [pjb_pkg::PROD_W-1:0]    a_prod_q;
  logic [pjb_pkg::SAMPLE_W-1:0]  b_quo_q, c_sample_q;
  pjb_pkg::status_t              a_st_q, b_st_q, c_st_q;
  logic [FILL_W-1:0]             a_fill_q, b_fill_q, c_fill_q;

  logic [MAG_W-1:0]              ext, mag;
  logic [MAG_W+pjb_pkg::VOL_W-1:0] prod;
  logic [FULL_W-1:0]             full;
  logic [pjb_pkg::SAMPLE_W-1:0]  signed_q;

  assign c_rdy   = !c_v_q || !out_stall_i;
  assign b_rdy   = !b_v_q || c_rdy;
  assign a_rdy   = !a_v_q || b_rdy;
  assign q_pop_o = q_valid_i && a_rdy;

  assign ext      = {q_sample_i[pjb_pkg::SAMPLE_W-1], q_sample_i};
  assign mag      = q_sample_i[pjb_pkg::SAMPLE_W-1] ? (~ext + MAG_W'(1)) : ext;
  assign prod     = (MAG_W + pjb_pkg::VOL_W)'(mag) * (MAG_W + pjb_pkg::VOL_W)'(volume_i);
  assign full     = FULL_W'(a_prod_q) * FULL_W'(pjb_pkg::DIV_MULT);
  assign signed_q = b_neg_q ? (~b_quo_q + pjb_pkg::SAMPLE_W'(1)) : b_quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (a_rdy) a_v_q <= q_valid_i;
      if (b_rdy) b_v_q <= a_v_q;
      if (c_rdy) c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy) begin
      a_neg_q  <= q_sample_i[pjb_pkg::SAMPLE_W-1];
      a_prod_q <= prod[pjb_pkg::PROD_W-1:0];
      a_st_q   <= q_status_i;
      a_fill_q <= q_fill_i;
    end
    if (b_rdy) begin
      b_neg_q  <= a_neg_q;
      b_quo_q  <= full[pjb_pkg::DIV_SHIFT+pjb_pkg::SAMPLE_W-1:pjb_pkg::DIV_SHIFT];
      b_st_q   <= a_st_q;
      b_fill_q <= a_fill_q;
    end
    if (c_rdy) begin
      c_sample_q <= signed_q;
      c_st_q     <= b_st_q;
      c_fill_q   <= b_fill_q;
    end
  end

  assign out_valid_o = c_v_q;
  assign sample_o    = c_sample_q;
  assign status_o    = c_st_q;
  assign fill_o      = c_fill_q;

endmodule

// File: hw/rtl/pcm_playback_jitter_buffer.sv
`timescale 1ns / 1ps
// Path: an accepted word passes the control update and sample read, the queue,
// then two scaling stages ahead of the output register; an output stall holds it.
// Throughput: one word per cycle while in_stall_o and out_stall_i are low; each
// word makes at most one access to the sample store, which has separate write and read ports.
// Reset: control state resets at once; sample storage stays uninitialized.
module pcm_playback_jitter_buffer #(
  parameter int FIFO_SAMPLES   = 8192,
  parameter int BLOCK_FRAMES   = 256,
  parameter int IDLE_STOP_TIME = 400,
  localparam int FILL_W        = $clog2(FIFO_SAMPLES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         cmd_i,
  input  logic signed [15:0] sample_in_i,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [7:0]         cfg_wdata_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_out_o,
  output logic signed [15:0] right_out_o,
  output logic               session_active_o,
  output logic [1:0]         events_o,
  output logic [FILL_W-1:0]  fill_level_o,
  output logic               block_last_o
);

  localparam int PTR_W = $clog2(FIFO_SAMPLES);
  localparam int ST_W  = $bits(pjb_pkg::status_t);
  localparam int QW    = pjb_pkg::SAMPLE_W + ST_W + FILL_W;

  logic                          st_we, st_re;
  logic [PTR_W-1:0]              st_waddr, st_raddr;
  logic [pjb_pkg::SAMPLE_W-1:0]  st_wdata, st_rdata;

  logic                          q_push, q_valid, q_pop;
  logic [pjb_pkg::QLVL_W-1:0]    q_level;
  logic [pjb_pkg::SAMPLE_W-1:0]  f_sample;
  pjb_pkg::status_t              f_status;
  logic [FILL_W-1:0]             f_fill;
  logic [QW-1:0]                 q_in, q_out;
  logic [pjb_pkg::VOL_W-1:0]     volume;

  logic [pjb_pkg::SAMPLE_W-1:0]  out_sample;
  pjb_pkg::status_t              out_status;

  pjb_front #(
    .FIFO_SAMPLES  (FIFO_SAMPLES),
    .BLOCK_FRAMES  (BLOCK_FRAMES),
    .IDLE_STOP_TIME(IDLE_STOP_TIME),
    .PTR_W         (PTR_W),
    .FILL_W        (FILL_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .sample_i   (sample_in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .q_level_i  (q_level),
    .q_push_o   (q_push),
    .q_sample_o (f_sample),
    .q_status_o (f_status),
    .q_fill_o   (f_fill),
    .volume_o   (volume),
    .st_we_o    (st_we),
    .st_waddr_o (st_waddr),
    .st_wdata_o (st_wdata),
    .st_re_o    (st_re),
    .st_raddr_o (st_raddr),
    .st_rdata_i (st_rdata)
  );

  pjb_store #(
    .DEPTH(FIFO_SAMPLES),
    .AW   (PTR_W)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  assign q_in = {f_fill, f_status, f_sample};

  pjb_queue #(
    .W(QW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_out),
    .level_o(q_level)
  );

  pjb_back #(
    .FILL_W(FILL_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .q_sample_i (q_out[pjb_pkg::SAMPLE_W-1:0]),
    .q_status_i (pjb_pkg::status_t'(q_out[pjb_pkg::SAMPLE_W+ST_W-1:pjb_pkg::SAMPLE_W])),
    .q_fill_i   (q_out[QW-1:pjb_pkg::SAMPLE_W+ST_W]),
    .volume_i   (volume),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sample_o   (out_sample),
    .status_o   (out_status),
    .fill_o     (fill_level_o)
  );

  assign left_out_o       = out_sample;
  assign right_out_o      = out_sample;
  assign session_active_o = out_status.active;
  assign events_o         = out_status.events;
  assign block_last_o     = out_status.last;

endmodule

// File: tb/pcm_playback_jitter_buffer_test.sv
`timescale 1ns / 1ps

module pcm_playback_jitter_buffer_test;

  localparam int FIFO_N         = 8192;
  localparam int BLOCK_N        = 256;
  localparam int IDLE_STOP      = 400;
  localparam int FILL_BITS      = $clog2(FIFO_N + 1);
  localparam int SILENCE_CAP    = 65535;
  localparam int DRAIN_WAIT     = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int FILL_WORDS     = 48;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_REPORTS    = 20;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic signed [15:0]   left;
    logic signed [15:0]   right;
    logic                 active;
    logic [1:0]           events;
    logic [FILL_BITS-1:0] fill;
    logic                 last;
  } frame_t;

  class jitter_scoreboard;
    logic [15:0] sample_mem [FIFO_N];
    int          rd_ptr = 0;
    int          wr_ptr = 0;
    int          held = 0;
    int          frame_idx = 0;
    int          block_got = 0;
    int          silent_span = 0;
    bit          running = 1'b0;
    logic [1:0]  ev_latch = '0;
    int          volume = pjb_pkg::VOL_RESET;
    int          period_ms = pjb_pkg::PERIOD_RESET;
    frame_t      expected_frames[$];
    int          errors = 0;
    int          frames_checked = 0;
    int          block_ends = 0;
    int          auto_stops = 0;
    int          overflows = 0;

    function void set_reg(logic idx, logic [7:0] data);
      if (idx == pjb_pkg::REG_VOLUME) begin
        volume = (data[6:0] > pjb_pkg::VOL_MAX) ? pjb_pkg::VOL_MAX : data[6:0];
      end else begin
        period_ms = data;
      end
    endfunction

    function void clear_fifo();
      rd_ptr = 0;
      wr_ptr = 0;
      held   = 0;
    endfunction

    function void accept_word(logic [2:0] cmd, logic [15:0] smp);
      frame_t f;
      int     scaled;
      f = '0;
      case (cmd)
        pjb_pkg::CMD_WRITE: begin
          if (running) begin
            if (held < FIFO_N) begin
              sample_mem[wr_ptr] = smp;
              wr_ptr = (wr_ptr + 1) % FIFO_N;
              held++;
            end else begin
              ev_latch[pjb_pkg::EV_OVERFLOW_BIT] = 1'b1;
              overflows++;
            end
          end
        end
        pjb_pkg::CMD_PULL: begin
          if (running) begin
            if (frame_idx == 0) begin
              block_got = (held < BLOCK_N) ? held : BLOCK_N;
              if (block_got < BLOCK_N) ev_latch[pjb_pkg::EV_UNDERRUN_BIT] = 1'b1;
            end
            if (frame_idx < block_got && held > 0) begin
              scaled  = ($signed(sample_mem[rd_ptr]) * volume) / 100;
              f.left  = scaled[15:0];
              f.right = scaled[15:0];
              rd_ptr  = (rd_ptr + 1) % FIFO_N;
              held--;
            end
            frame_idx++;
            if (frame_idx >= BLOCK_N) begin
              f.last    = 1'b1;
              frame_idx = 0;
              block_ends++;
              if (block_got == 0) begin
                silent_span += (period_ms == 0) ? 1 : period_ms;
                if (silent_span > SILENCE_CAP) silent_span = SILENCE_CAP;
              end else begin
                silent_span = 0;
              end
              if (silent_span >= IDLE_STOP) begin
                running = 1'b0;
                auto_stops++;
              end
            end
          end
        end
        pjb_pkg::CMD_START: begin
          if (!running) begin
            clear_fifo();
            ev_latch    = '0;
            frame_idx   = 0;
            block_got   = 0;
            silent_span = 0;
            running     = 1'b1;
          end
        end
        pjb_pkg::CMD_STOP: running = 1'b0;
        pjb_pkg::CMD_FLUSH: begin
          clear_fifo();
          running = 1'b0;
        end
        default: ;
      endcase
      f.active = running;
      f.events = ev_latch;
      f.fill   = held[FILL_BITS-1:0];
      if (cmd == pjb_pkg::CMD_CLEAR_EV) ev_latch = '0;
      expected_frames.push_back(f);
    endfunction

    function void check_frame(frame_t got);
      frame_t want;
      if (expected_frames.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected word: L=%0d R=%0d act=%0b ev=%0b fill=%0d last=%0b",
                   $time, got.left, got.right, got.active, got.events, got.fill, got.last);
        return;
      end
      want = expected_frames.pop_front();
      frames_checked++;
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch: expected L=%0d R=%0d act=%0b ev=%0b fill=%0d last=%0b, %s",
                   $time, want.left, want.right, want.active, want.events, want.fill,
                   want.last,
                   $sformatf("got L=%0d R=%0d act=%0b ev=%0b fill=%0d last=%0b",
                             got.left, got.right, got.active, got.events, got.fill,
                             got.last));
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [2:0]           cmd_i;
  logic signed [15:0]   sample_in_i;
  logic                 cfg_we_i;
  logic                 cfg_idx_i;
  logic [7:0]           cfg_wdata_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic signed [15:0]   left_out_o;
  logic signed [15:0]   right_out_o;
  logic                 session_active_o;
  logic [1:0]           events_o;
  logic [FILL_BITS-1:0] fill_level_o;
  logic                 block_last_o;

  jitter_scoreboard sb = new();
  frame_t           seen_frame;
  bit               tx_idle_on = 1'b1;
  bit               rx_idle_on = 1'b1;
  bit               hold_kick = 1'b0;
  int               hold_left = 0;
  int               quiet_cycles = 0;
  int               words_sent = 0;

  pcm_playback_jitter_buffer dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cmd_i            (cmd_i),
    .sample_in_i      (sample_in_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .left_out_o       (left_out_o),
    .right_out_o      (right_out_o),
    .session_active_o (session_active_o),
    .events_o         (events_o),
    .fill_level_o     (fill_level_o),
    .block_last_o     (block_last_o)
  );

  always #6 clk_i = ~clk_i;

  // output side: random stall, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_frame.left   = left_out_o;
      seen_frame.right  = right_out_o;
      seen_frame.active = session_active_o;
      seen_frame.events = events_o;
      seen_frame.fill   = fill_level_o;
      seen_frame.last   = block_last_o;
      sb.check_frame(seen_frame);
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (hold_kick) begin
      hold_kick = 1'b0;
      hold_left = HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= rx_idle_on && ($urandom_range(99) < 38);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("pcm_playback_jitter_buffer_test: FAIL");
        $finish;
      end
    end
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [2:0] cmd, input logic [15:0] smp);
    while (tx_idle_on && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    sample_in_i <= smp;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.accept_word(cmd, smp);
    words_sent++;
  endtask

  task automatic send_burst(input logic [2:0] cmd, input int count);
    repeat (count) send_word(cmd, pick_sample());
  endtask

  // wait for every outstanding word, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_frames.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] data);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic random_session(input int budget);
    int n;
    send_word(pjb_pkg::CMD_START, pick_sample());
    while (budget > 0) begin
      n = $urandom_range(99);
      if (n < 40) begin
        n = $urandom_range(1, 12);
        send_burst(pjb_pkg::CMD_WRITE, n);
        budget -= n;
      end else if (n < 80) begin
        n = $urandom_range(1, 12);
        send_burst(pjb_pkg::CMD_PULL, n);
        budget -= n;
      end else begin
        if (n < 85)      send_word(pjb_pkg::CMD_CLEAR_EV, pick_sample());
        else if (n < 88) send_word(pjb_pkg::CMD_STOP, pick_sample());
        else if (n < 91) send_word(pjb_pkg::CMD_FLUSH, pick_sample());
        else if (n < 95) send_word(pjb_pkg::CMD_START, pick_sample());
        else             send_word((n % 2) ? CMD_SPARE_A : CMD_SPARE_B, pick_sample());
        budget--;
      end
    end
  endtask

  initial begin
    int k;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    cmd_i       <= pjb_pkg::CMD_WRITE;
    sample_in_i <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= pjb_pkg::REG_VOLUME;
    cfg_wdata_i <= '0;
    out_stall_i <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(pjb_pkg::REG_VOLUME, 8'd37);
    write_reg(pjb_pkg::REG_PERIOD, 8'd255);

    // idle-state commands, then a short session with truncation corners
    send_word(pjb_pkg::CMD_PULL, 16'h1111);
    send_word(pjb_pkg::CMD_WRITE, 16'h1234);
    send_word(CMD_SPARE_A, 16'hFFFF);
    send_word(CMD_SPARE_B, 16'h0000);
    send_word(pjb_pkg::CMD_STOP, 16'h0000);
    send_word(pjb_pkg::CMD_FLUSH, 16'h0000);
    send_word(pjb_pkg::CMD_CLEAR_EV, 16'h0000);
    send_word(pjb_pkg::CMD_START, 16'h0000);
    send_word(pjb_pkg::CMD_START, 16'h0000);
    send_word(pjb_pkg::CMD_WRITE, 16'h7FFF);
    send_word(pjb_pkg::CMD_WRITE, 16'h8000);
    send_word(pjb_pkg::CMD_WRITE, 16'hFFFF);
    send_word(pjb_pkg::CMD_WRITE, 16'h0001);
    send_word(pjb_pkg::CMD_WRITE, 16'hFF9C);
    send_word(pjb_pkg::CMD_WRITE, 16'h0063);
    send_burst(pjb_pkg::CMD_PULL, 7);
    send_word(pjb_pkg::CMD_CLEAR_EV, 16'h0000);
    send_word(pjb_pkg::CMD_CLEAR_EV, 16'h0000);
    send_word(pjb_pkg::CMD_FLUSH, 16'h0000);
    send_word(pjb_pkg::CMD_START, 16'h0000);
    send_word(pjb_pkg::CMD_WRITE, 16'h5555);
    send_word(pjb_pkg::CMD_STOP, 16'h0000);
    send_word(pjb_pkg::CMD_PULL, 16'h0000);

    // writes with the output held off and no idling, one partly filled block,
    // then two silent blocks at 255 ms end the session
    write_reg(pjb_pkg::REG_VOLUME, 8'd100);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_word(pjb_pkg::CMD_START, pick_sample());
    for (k = 0; k < FILL_WORDS; k++) begin
      if (k == 8) hold_kick = 1'b1;
      send_word(pjb_pkg::CMD_WRITE, pick_sample());
    end
    send_burst(pjb_pkg::CMD_PULL, BLOCK_N);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_burst(pjb_pkg::CMD_PULL, 2 * BLOCK_N + 2);

    for (k = 0; k < 5; k++) begin
      case (k)
        0: begin
          write_reg(pjb_pkg::REG_VOLUME, 8'd0);
          write_reg(pjb_pkg::REG_PERIOD, 8'd1);
        end
        1: begin
          write_reg(pjb_pkg::REG_VOLUME, 8'd255);
          write_reg(pjb_pkg::REG_PERIOD, 8'd0);
        end
        2: begin
          write_reg(pjb_pkg::REG_VOLUME, 8'd200);
          write_reg(pjb_pkg::REG_PERIOD, 8'd16);
        end
        3: begin
          write_reg(pjb_pkg::REG_VOLUME, 8'd101);
          write_reg(pjb_pkg::REG_PERIOD, 8'd255);
        end
        default: begin
          write_reg(pjb_pkg::REG_VOLUME, 8'($urandom_range(100)));
          write_reg(pjb_pkg::REG_PERIOD, 8'($urandom_range(1, 255)));
        end
      endcase
      tx_idle_on = (k != 2);
      rx_idle_on = (k != 2);
      random_session(16);
    end

    settle();
    $display("run covered %0d words, %0d frames checked, %0d completed blocks",
             words_sent, sb.frames_checked, sb.block_ends);
    $display("%0d dropped writes on a full buffer, %0d sessions ended by silence",
             sb.overflows, sb.auto_stops);
    if (sb.errors == 0 && sb.expected_frames.size() == 0) begin
      $display("pcm_playback_jitter_buffer_test: PASS");
    end else begin
      $display("pcm_playback_jitter_buffer_test: FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/pjb_pkg.sv
hw/rtl/pjb_store.sv
hw/rtl/pjb_queue.sv
hw/rtl/pjb_front.sv
hw/rtl/pjb_back.sv
hw/rtl/pcm_playback_jitter_buffer.sv
tb/pcm_playback_jitter_buffer_test.sv
